// ===== hdl/base64_stream_encoder_defines.svh =====
// assertion macros shared by the base64 encoder checker
// expects clk and rst to be visible where a macro is used
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define B64E_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// consequent must hold in the cycle after the antecedent
`define B64E_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

// ===== hdl/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 encoder
// no dependencies
package b64e_pkg;

  // input transaction: one message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  // output transaction: one ascii character
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } char_item_t;

  // one output character before ascii mapping
  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } sym_t;

  localparam int SLOTS = 4;
  localparam int SLOT_W = $clog2(SLOTS);

  // characters produced by one accepted byte
  typedef struct packed {
    logic [SLOT_W-1:0] last_slot;
    logic              last;
    sym_t [SLOTS-1:0]  slot;
  } job_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] sym_to_ascii(input sym_t s);
    logic [7:0] v;
    logic [7:0] c;
    v = {2'b00, s.idx};
    if (s.pad) begin
      c = PAD_CHAR;
    end else if (v < 8'd26) begin
      c = v + 8'd65;
    end else if (v < 8'd52) begin
      c = v + 8'd71;
    end else if (v < 8'd62) begin
      c = v - 8'd4;
    end else if (v == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hdl/base64_stream_encoder.sv =====
// top level of the streaming base64 encoder
// uses b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// Encodes a byte stream to padded standard base64, one input byte per
// transaction and one ascii character per output transaction; a final
// byte that leaves its group short closes it with the flush character and
// '=' pads, and the last character carries out_last. Bytes are taken one
// per cycle as long as the four-entry job queue has room, and characters
// leave one per cycle from the output register while the receiver does not
// stall, so the output port sets the rate: 4 characters per 3 bytes on
// average; a final byte that starts a group yields 4 characters. An
// accepted byte is queued, then its first character is registered.
module base64_stream_encoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  b64e_pkg::byte_item_t  byte_data,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64e_pkg::char_item_t  char_data
);

  logic           accept;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  b64e_pkg::job_t new_job;
  b64e_pkg::job_t head_job;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  // byte classification
  b64e_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_data),
    .job    (new_job)
  );

  // decoupling queue
  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (new_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_job)
  );

  // character emission
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head       (head_job),
    .pop        (q_pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule

// ===== hdl/b64e_front.sv =====
// front end: tracks the byte position in its group and splits each byte
// into a job of one to four characters; uses b64e_pkg
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  b64e_pkg::byte_item_t item,
  output b64e_pkg::job_t      job
);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;

  // classify the byte against the current group position
  always_comb begin
    logic [7:0] b;
    b = item.data_byte;
    job = '0;
    job.last = item.final_byte;
    phase_next = PH_START;
    carry_next = 4'd0;
    unique case (phase)
      PH_SECOND: begin
        job.slot[0].idx = {carry[1:0], b[7:4]};
        if (item.final_byte) begin
          job.slot[1].idx = {b[3:0], 2'b00};
          job.slot[2].pad = 1'b1;
          job.last_slot = b64e_pkg::SLOT_W'(2);
        end else begin
          carry_next = b[3:0];
          phase_next = PH_THIRD;
        end
      end
      PH_THIRD: begin
        job.slot[0].idx = {carry, b[7:6]};
        job.slot[1].idx = b[5:0];
        job.last_slot = b64e_pkg::SLOT_W'(1);
      end
      default: begin
        job.slot[0].idx = b[7:2];
        if (item.final_byte) begin
          job.slot[1].idx = {b[1:0], 4'b0000};
          job.slot[2].pad = 1'b1;
          job.slot[3].pad = 1'b1;
          job.last_slot = b64e_pkg::SLOT_W'(3);
        end else begin
          carry_next = {2'b00, b[1:0]};
          phase_next = PH_SECOND;
        end
      end
    endcase
  end

  // group position and leftover bits
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

// ===== hdl/b64e_queue.sv =====
// short job queue between front and back end
// uses b64e_pkg for the job type and depth
module b64e_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64e_pkg::job_t    push_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output b64e_pkg::job_t    head
);

  b64e_pkg::job_t                entries [b64e_pkg::Q_DEPTH];
  logic [b64e_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [b64e_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [b64e_pkg::Q_CNT_W-1:0] count;

  assign full  = (count == b64e_pkg::Q_CNT_W'(b64e_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/b64e_back.sv =====
// back end: walks the head job one character per cycle into the output
// register while the output is not stalled; uses b64e_pkg
module b64e_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  b64e_pkg::job_t        head,
  output logic                  pop,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64e_pkg::char_item_t  char_data
);

  logic [b64e_pkg::SLOT_W-1:0] sel;
  logic                        load;
  logic                        at_end;

  assign load   = head_valid && (!char_valid || !char_stall);
  assign at_end = (sel == head.last_slot);
  assign pop    = load && at_end;

  // slot pointer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sel        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        sel <= at_end ? '0 : sel + 1'b1;
      end
      if (load) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_data.out_char <= b64e_pkg::sym_to_ascii(head.slot[sel]);
      char_data.out_last <= head.last && at_end;
    end
  end

endmodule

// ===== hdl/b64e_checker.sv =====
// port-level checks for the base64 encoder, bound to the top level
// uses b64e_pkg and base64_stream_encoder_defines.svh
`include "base64_stream_encoder_defines.svh"

module b64e_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 byte_valid,
  input logic                 byte_stall,
  input b64e_pkg::byte_item_t byte_data,
  input logic                 char_valid,
  input logic                 char_stall,
  input b64e_pkg::char_item_t char_data
);

  logic [7:0] c;
  logic       char_ok;
  logic       pad_open;

  assign c = char_data.out_char;
  assign char_ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39) || (c == 8'h2B) || (c == 8'h2F) ||
                   (c == b64e_pkg::PAD_CHAR);

  // a first pad that is not last leaves the second pad owed
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_open <= 1'b0;
    end else if (char_valid && !char_stall) begin
      pad_open <= (c == b64e_pkg::PAD_CHAR) && !char_data.out_last;
    end
  end

  // a stalled byte transaction holds
  `B64E_ASSERT_NEXT(a_byte_hold, byte_valid && byte_stall,
                    byte_valid && $stable(byte_data))

  // a stalled character transaction holds
  `B64E_ASSERT_NEXT(a_char_hold, char_valid && char_stall, char_valid && $stable(char_data))

  // only alphabet characters and pads leave the block
  `B64E_ASSERT_NOW(a_char_legal, char_valid, char_ok)

  // the character after a non-final pad is the closing pad
  `B64E_ASSERT_NOW(a_pad_pair, char_valid && pad_open,
                   c == b64e_pkg::PAD_CHAR && char_data.out_last)

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);

// ===== sim/base64_stream_encoder_tb.sv =====
// self-checking testbench for the streaming base64 encoder
// depends on b64e_pkg and base64_stream_encoder from the hdl folder
module base64_stream_encoder_tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [8*64-1:0] B64_LETTERS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic [1:0] {PH_START, PH_MID, PH_END} group_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  b64e_pkg::byte_item_t byte_data = '0;
  logic                 char_valid;
  logic                 char_stall = 1'b0;
  b64e_pkg::char_item_t char_data;

  // encoder state mirrored by the predictor
  group_phase_t enc_phase = PH_START;
  logic [3:0]   enc_carry = '0;

  b64e_pkg::char_item_t pending_chars[$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         cycle_count = 0;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  base64_stream_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_data (char_data)
  );

  always #5 clk = ~clk;

  // six-bit value to its ascii letter
  function automatic logic [7:0] letter(input logic [5:0] six);
    return B64_LETTERS[8*(63 - six) +: 8];
  endfunction

  task automatic expect_char(input logic [7:0] c, input logic last);
    b64e_pkg::char_item_t item;
    item.out_char = c;
    item.out_last = last;
    pending_chars.push_back(item);
  endtask

  // expected characters for one accepted byte
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    case (enc_phase)
      PH_MID: begin
        expect_char(letter({enc_carry[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          expect_char(letter({b[3:0], 2'b00}), 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b1);
          enc_phase = PH_START;
          enc_carry = '0;
        end else begin
          enc_carry = b[3:0];
          enc_phase = PH_END;
        end
      end
      PH_END: begin
        expect_char(letter({enc_carry, b[7:6]}), 1'b0);
        expect_char(letter(b[5:0]), fin);
        enc_phase = PH_START;
        enc_carry = '0;
      end
      default: begin
        expect_char(letter(b[7:2]), 1'b0);
        if (fin) begin
          expect_char(letter({b[1:0], 4'b0000}), 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b0);
          expect_char(b64e_pkg::PAD_CHAR, 1'b1);
          enc_phase = PH_START;
          enc_carry = '0;
        end else begin
          enc_carry = {2'b00, b[1:0]};
          enc_phase = PH_MID;
        end
      end
    endcase
  endtask

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data.data_byte <= b;
    byte_data.final_byte <= fin;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    encode_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1);
    end
  endtask

  // final byte at the start of a group: flush plus two pads
  task automatic test_single_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFC, 1'b1);
    send_byte(8'h03, 1'b1);
  endtask

  // final byte in the middle and at the end of a group
  task automatic test_partial_groups();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // messages spanning more than one group, back to back
  task automatic test_multi_group_messages();
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hF0, 1'b1);
  endtask

  // random messages, mostly short, with idling switched per message
  task automatic test_random_messages(input int target);
    int len;
    while (bytes_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      send_message(len);
    end
    idle_on = 1'b1;
  endtask

  // full rate on both sides to close the run
  task automatic test_unthrottled_tail(input int target);
    idle_on = 1'b0;
    while (bytes_sent < target) begin
      send_message($urandom_range(1, 9));
    end
  endtask

  // receiver stall bursts, started only while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      char_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      char_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      char_stall <= 1'b0;
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk) begin
    b64e_pkg::char_item_t want;
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h last %b", char_data.out_char, char_data.out_last);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (char_data.out_char !== want.out_char) begin
          $error("out_char expected %h actual %h", want.out_char, char_data.out_char);
          mismatch_count++;
        end
        if (char_data.out_last !== want.out_last) begin
          $error("out_last expected %b actual %b", want.out_last, char_data.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_byte_messages();
    test_partial_groups();
    test_multi_group_messages();
    test_random_messages(170);
    test_unthrottled_tail(205);
    byte_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== base64_stream_encoder.f =====
+incdir+hdl
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
hdl/b64e_checker.sv
sim/base64_stream_encoder_tb.sv
